// ===== hdl/cmd3_pkg.sv =====
// ----------------------------------------------------------------------------
// cmd3_pkg: shared types and constants
// Widths, mesh geometry and the request queue entry for the mass deposit mesh.
// ----------------------------------------------------------------------------
package cmd3_pkg;
	localparam int GRID_BITS = 6;
	localparam int FRAC_BITS = 16;
	localparam int SUM_BITS  = 48;
	localparam int POS_BITS  = 22;
	localparam int MASS_BITS = 32;
	localparam int ADDR_BITS = 3 * GRID_BITS;
	localparam int CELLS     = 1 << ADDR_BITS;
	localparam int WT_BITS   = FRAC_BITS + 1;
	localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
	localparam logic [FRAC_BITS-1:0] HALF_FX = FRAC_BITS'(1) << (FRAC_BITS - 1);

	typedef enum logic {REQ_DEPOSIT = 1'b0, REQ_READ = 1'b1} req_t;

	// one classified request between front and back
	typedef struct packed {
		req_t                 kind;
		logic [GRID_BITS-1:0] cx;
		logic [GRID_BITS-1:0] cy;
		logic [GRID_BITS-1:0] cz;
		logic [FRAC_BITS-1:0] tx;
		logic [FRAC_BITS-1:0] ty;
		logic [FRAC_BITS-1:0] tz;
		logic [MASS_BITS-1:0] mass;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_WEIGHT, ST_MUL, ST_READ, ST_WRITE, ST_OUT
	} state_t;
endpackage

// ===== hdl/cic_mass_deposit_3d.sv =====
// ----------------------------------------------------------------------------
// cic_mass_deposit_3d: cloud-in-cell mass deposit on a periodic 64^3 mesh
//
// Input channel req_valid/req_stall carries deposit or read requests.
// A deposit adds trilinear-weighted mass to eight cells and gives no result.
// A read returns one cell's 48-bit sum and saturation flag on res_valid /
// res_stall and clears the cell.
// Requests enter a four-entry queue, so the input keeps flowing while the
// mesh engine works or a result waits on a stalled receiver.
// Steps: a deposit pops the queue, then per corner runs two weight products, a
// read and a write through the single mesh port. A read pops, reads, writes the
// cleared cell and presents the result. The engine starts the next request only after the last one is done.
// After reset the engine clears the mesh, one cell per cycle, over all 262144 cells;
// up to four requests are queued meanwhile, then the input stalls until the
// sweep ends.
// A stalled result holds its value; the engine waits until it is taken.
// ----------------------------------------------------------------------------
module cic_mass_deposit_3d (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           req_type,
	input  logic [cmd3_pkg::POS_BITS-1:0]  pos_x,
	input  logic [cmd3_pkg::POS_BITS-1:0]  pos_y,
	input  logic [cmd3_pkg::POS_BITS-1:0]  pos_z,
	input  logic [cmd3_pkg::MASS_BITS-1:0] particle_mass,
	input  logic [cmd3_pkg::GRID_BITS-1:0] cell_x,
	input  logic [cmd3_pkg::GRID_BITS-1:0] cell_y,
	input  logic [cmd3_pkg::GRID_BITS-1:0] cell_z,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [cmd3_pkg::SUM_BITS-1:0]  cell_mass_sum,
	output logic                           saturated
);
	import cmd3_pkg::*;

	logic q_valid, q_pop;
	cmd_t q_cmd;

	cmd3_front u_front (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req_type(req_type), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.particle_mass(particle_mass), .cell_x(cell_x), .cell_y(cell_y),
		.cell_z(cell_z), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
	);

	cmd3_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(q_cmd),
		.q_pop(q_pop), .res_valid(res_valid), .res_stall(res_stall),
		.cell_mass_sum(cell_mass_sum), .saturated(saturated)
	);
endmodule

// ===== hdl/cmd3_ram.sv =====
// ----------------------------------------------------------------------------
// cmd3_ram: generic single port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module cmd3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== hdl/cmd3_front.sv =====
// ----------------------------------------------------------------------------
// cmd3_front: request classifier and queue
// Splits deposit positions into lower cell and fraction, takes the cell of a read, and queues the request.
// ----------------------------------------------------------------------------
module cmd3_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic                            req_type,
	input  logic [cmd3_pkg::POS_BITS-1:0]   pos_x,
	input  logic [cmd3_pkg::POS_BITS-1:0]   pos_y,
	input  logic [cmd3_pkg::POS_BITS-1:0]   pos_z,
	input  logic [cmd3_pkg::MASS_BITS-1:0]  particle_mass,
	input  logic [cmd3_pkg::GRID_BITS-1:0]  cell_x,
	input  logic [cmd3_pkg::GRID_BITS-1:0]  cell_y,
	input  logic [cmd3_pkg::GRID_BITS-1:0]  cell_z,
	output logic                            q_valid,
	output cmd3_pkg::cmd_t                  q_cmd,
	input  logic                            q_pop
);
	import cmd3_pkg::*;

	localparam int QD = 4;
	localparam int QB = $clog2(QD);
	localparam int SPAN = GRID_BITS + FRAC_BITS;

	cmd_t          mem_q [QD];
	logic [QB-1:0] wp_q, rp_q;
	logic [QB:0]   cnt_q;
	cmd_t          c;
	logic [SPAN-1:0] qx, qy, qz;
	logic          push;

	// subtract half a cell modulo the mesh span
	always_comb begin
		qx = pos_x[SPAN-1:0] - SPAN'(HALF_FX);
		qy = pos_y[SPAN-1:0] - SPAN'(HALF_FX);
		qz = pos_z[SPAN-1:0] - SPAN'(HALF_FX);
		c.kind = req_t'(req_type);
		c.mass = particle_mass;
		if (req_type) begin
			c.cx = cell_x; c.cy = cell_y; c.cz = cell_z;
			c.tx = '0; c.ty = '0; c.tz = '0;
		end else begin
			c.cx = qx[SPAN-1:FRAC_BITS];
			c.cy = qy[SPAN-1:FRAC_BITS];
			c.cz = qz[SPAN-1:FRAC_BITS];
			c.tx = qx[FRAC_BITS-1:0];
			c.ty = qy[FRAC_BITS-1:0];
			c.tz = qz[FRAC_BITS-1:0];
		end
	end

	assign req_stall = (cnt_q == (QB+1)'(QD));
	assign push      = req_valid && !req_stall;
	assign q_valid   = (cnt_q != '0);
	assign q_cmd     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QB+1)'(push) - (QB+1)'(q_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (QB+1)'(QD))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count not advanced on push");
endmodule

// ===== hdl/cmd3_back.sv =====
// ----------------------------------------------------------------------------
// cmd3_back: mesh update engine
// Runs eight read-modify-writes per deposit, or a read and clear, on the mesh; clears the mesh after reset.
// ----------------------------------------------------------------------------
module cmd3_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  cmd3_pkg::cmd_t                 q_cmd,
	output logic                           q_pop,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [cmd3_pkg::SUM_BITS-1:0]  cell_mass_sum,
	output logic                           saturated
);
	import cmd3_pkg::*;

	localparam int PW = 2 * WT_BITS;
	localparam int AMT = MASS_BITS + WT_BITS;

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [2:0]            corner_q;
	logic [ADDR_BITS-1:0]  clr_q;
	logic [WT_BITS-1:0]    w2_q, wz_q, w3_q;
	logic [AMT-1:0]        amt_q;
	logic [SUM_BITS-1:0]   out_sum_q;
	logic                  out_sat_q, out_v_q;

	logic                  we;
	logic [ADDR_BITS-1:0]  addr;
	logic [SUM_BITS:0]     wdata, rdata;
	logic [GRID_BITS-1:0]  ax, ay, az;
	logic [WT_BITS-1:0]    wx, wy;
	logic [PW-1:0]         pxy, pz;
	logic [SUM_BITS-1:0]   room;

	cmd3_ram #(.WIDTH(SUM_BITS + 1), .DEPTH(CELLS)) u_mesh (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	// corner bits: [0] x upper, [1] y upper, [2] z upper
	always_comb begin
		ax = cmd_q.cx + GRID_BITS'(corner_q[0] && cmd_q.kind == REQ_DEPOSIT);
		ay = cmd_q.cy + GRID_BITS'(corner_q[1] && cmd_q.kind == REQ_DEPOSIT);
		az = cmd_q.cz + GRID_BITS'(corner_q[2] && cmd_q.kind == REQ_DEPOSIT);
		wx = corner_q[0] ? {1'b0, cmd_q.tx} : (WT_BITS'(1) << FRAC_BITS) - WT_BITS'(cmd_q.tx);
		wy = corner_q[1] ? {1'b0, cmd_q.ty} : (WT_BITS'(1) << FRAC_BITS) - WT_BITS'(cmd_q.ty);
		pxy = wx * wy;
		pz  = w2_q * wz_q;
		room = SUM_MAX - rdata[SUM_BITS-1:0];
	end

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		we = 1'b0;
		addr = {az, ay, ax};
		wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				addr = clr_q;
				we = 1'b1;
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					state_d = (q_cmd.kind == REQ_READ) ? ST_READ : ST_WEIGHT;
				end
			end
			ST_WEIGHT: state_d = ST_MUL;
			ST_MUL:    state_d = ST_READ;
			ST_READ:   state_d = ST_WRITE;
			ST_WRITE: begin
				we = 1'b1;
				if (cmd_q.kind == REQ_READ) begin
					wdata = '0;
					state_d = ST_OUT;
				end else begin
					if (SUM_BITS'(amt_q) >= room || (amt_q >> SUM_BITS) != '0)
						wdata = {1'b1, SUM_MAX};
					else
						wdata = {rdata[SUM_BITS], rdata[SUM_BITS-1:0] + SUM_BITS'(amt_q)};
					state_d = (corner_q == 3'd7) ? ST_IDLE : ST_WEIGHT;
				end
			end
			ST_OUT: if (!out_v_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			corner_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (q_pop) corner_q <= '0;
			else if (state_q == ST_WRITE) corner_q <= corner_q + 1'b1;
			if (state_q == ST_WRITE && cmd_q.kind == REQ_READ) out_v_q <= 1'b1;
			else if (out_v_q && !res_stall) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_cmd;
		if (state_q == ST_WEIGHT) begin
			w2_q <= WT_BITS'((pxy + PW'(HALF_FX)) >> FRAC_BITS);
			wz_q <= corner_q[2] ? {1'b0, cmd_q.tz} :
				(WT_BITS'(1) << FRAC_BITS) - WT_BITS'(cmd_q.tz);
		end
		if (state_q == ST_MUL) w3_q <= WT_BITS'((pz + PW'(HALF_FX)) >> FRAC_BITS);
		if (state_q == ST_READ) amt_q <= cmd_q.mass * w3_q;
		if (state_q == ST_WRITE && cmd_q.kind == REQ_READ) begin
			out_sum_q <= rdata[SUM_BITS-1:0];
			out_sat_q <= rdata[SUM_BITS];
		end
	end

	assign res_valid = out_v_q;
	assign cell_mass_sum = out_sum_q;
	assign saturated = out_sat_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == ST_IDLE)
		else $error("pop outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> state_q == ST_OUT || state_q == ST_IDLE)
		else $error("result pending during mesh update");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && cmd_q.kind == REQ_READ) |=> res_valid)
		else $error("read result lost");
endmodule

// ===== sim/cic_mass_deposit_3d_chk.sv =====
// ----------------------------------------------------------------------------
// cic_mass_deposit_3d_chk: scoreboard for the mass deposit mesh
// Keeps its own copy of the mesh sums, predicts each read result from the
// accepted requests and compares every delivered result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cic_mass_deposit_3d_chk
	import cmd3_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  logic                 req_type,
	input  logic [POS_BITS-1:0]  pos_x,
	input  logic [POS_BITS-1:0]  pos_y,
	input  logic [POS_BITS-1:0]  pos_z,
	input  logic [MASS_BITS-1:0] particle_mass,
	input  logic [GRID_BITS-1:0] cell_x,
	input  logic [GRID_BITS-1:0] cell_y,
	input  logic [GRID_BITS-1:0] cell_z,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  logic [SUM_BITS-1:0]  cell_mass_sum,
	input  logic                 saturated,
	output int                   fail_count,
	output int                   sums_pending,
	output int                   deposit_count,
	output int                   read_count,
	output int                   sat_seen
);
	typedef struct {
		logic [SUM_BITS-1:0] sum;
		logic                sat;
	} cell_value_t;

	// sparse mesh image; absent entries are zero
	logic [SUM_BITS-1:0] mesh_sum [int];
	logic                mesh_sat [int];
	cell_value_t         sum_queue [$];

	function automatic int cell_addr(logic [GRID_BITS-1:0] x, logic [GRID_BITS-1:0] y,
			logic [GRID_BITS-1:0] z);
		return int'({z, y, x});
	endfunction

	// shift by half a cell so q indexes the lower bracketing centre
	function automatic logic [POS_BITS-1:0] centre_offset(logic [POS_BITS-1:0] p);
		return p - POS_BITS'(HALF_FX);
	endfunction

	function automatic logic [63:0] round_fx(logic [63:0] v);
		return (v + 64'(HALF_FX)) >> FRAC_BITS;
	endfunction

	task automatic add_mass(int a, logic [63:0] amount);
		logic [63:0] s;
		s = mesh_sum.exists(a) ? 64'(mesh_sum[a]) : 64'd0;
		if (amount >= 64'(SUM_MAX) - s) begin
			mesh_sum[a] = SUM_MAX;
			mesh_sat[a] = 1'b1;
		end else begin
			mesh_sum[a] = SUM_BITS'(s + amount);
		end
	endtask

	task automatic deposit_particle();
		logic [POS_BITS-1:0]  q [3];
		logic [GRID_BITS-1:0] lo [3];
		logic [63:0]          w [3][2];
		logic [63:0]          w2, w3;
		logic [GRID_BITS-1:0] cx, cy, cz;
		q[0] = centre_offset(pos_x);
		q[1] = centre_offset(pos_y);
		q[2] = centre_offset(pos_z);
		for (int k = 0; k < 3; k++) begin
			lo[k]   = q[k][POS_BITS-1:FRAC_BITS];
			w[k][1] = 64'(q[k][FRAC_BITS-1:0]);
			w[k][0] = (64'd1 << FRAC_BITS) - w[k][1];
		end
		for (int c = 0; c < 2; c++)
			for (int b = 0; b < 2; b++)
				for (int a = 0; a < 2; a++) begin
					w2 = round_fx(w[0][a] * w[1][b]);
					w3 = round_fx(w2 * w[2][c]);
					cx = lo[0] + GRID_BITS'(a);
					cy = lo[1] + GRID_BITS'(b);
					cz = lo[2] + GRID_BITS'(c);
					add_mass(cell_addr(cx, cy, cz), 64'(particle_mass) * w3);
				end
	endtask

	task automatic read_cell();
		cell_value_t v;
		int a;
		a = cell_addr(cell_x, cell_y, cell_z);
		v.sum = mesh_sum.exists(a) ? mesh_sum[a] : '0;
		v.sat = mesh_sat.exists(a) ? mesh_sat[a] : 1'b0;
		mesh_sum.delete(a);
		mesh_sat.delete(a);
		sum_queue.push_back(v);
	endtask

	task automatic report(string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%t mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		cell_value_t want;
		if (!arst_n) begin
			fail_count    <= 0;
			deposit_count <= 0;
			read_count    <= 0;
			sat_seen      <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (sum_queue.size() == 0) begin
					report($sformatf("unexpected result sum=%h sat=%b",
						cell_mass_sum, saturated));
				end else begin
					want = sum_queue.pop_front();
					if (cell_mass_sum !== want.sum)
						report($sformatf("cell_mass_sum exp %h got %h", want.sum,
							cell_mass_sum));
					if (saturated !== want.sat)
						report($sformatf("saturated exp %b got %b", want.sat, saturated));
					if (want.sat)
						sat_seen <= sat_seen + 1;
				end
			end
			if (req_valid && !req_stall) begin
				if (req_t'(req_type) == REQ_READ) begin
					read_cell();
					read_count <= read_count + 1;
				end else begin
					deposit_particle();
					deposit_count <= deposit_count + 1;
				end
			end
		end
	end

	assign sums_pending = sum_queue.size();
endmodule

// ===== sim/cic_mass_deposit_3d_tb.sv =====
// ----------------------------------------------------------------------------
// cic_mass_deposit_3d_tb: testbench top for the mass deposit mesh
// Drives directed and random deposit/read requests under varying sender gaps
// and receiver stalls; the checker predicts and compares each read result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cic_mass_deposit_3d_tb;
	import cmd3_pkg::*;

	localparam int  RAND_ITEMS  = 1620;
	localparam int  CYCLE_LIMIT = 4000000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic                 req_type = 1'b0;
	logic [POS_BITS-1:0]  pos_x = '0;
	logic [POS_BITS-1:0]  pos_y = '0;
	logic [POS_BITS-1:0]  pos_z = '0;
	logic [MASS_BITS-1:0] particle_mass = '0;
	logic [GRID_BITS-1:0] cell_x = '0;
	logic [GRID_BITS-1:0] cell_y = '0;
	logic [GRID_BITS-1:0] cell_z = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [SUM_BITS-1:0]  cell_mass_sum;
	logic                 saturated;

	int fail_count, sums_pending, deposit_count, read_count, sat_seen;
	int idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;

	always #6 clk = ~clk;

	cic_mass_deposit_3d i_dut (.*);

	cic_mass_deposit_3d_chk i_chk (.*);

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send(req_t kind, logic [POS_BITS-1:0] px, logic [POS_BITS-1:0] py,
			logic [POS_BITS-1:0] pz, logic [MASS_BITS-1:0] m,
			logic [GRID_BITS-1:0] x, logic [GRID_BITS-1:0] y, logic [GRID_BITS-1:0] z);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid     <= 1'b1;
		req_type      <= kind;
		pos_x         <= px;
		pos_y         <= py;
		pos_z         <= pz;
		particle_mass <= m;
		cell_x        <= x;
		cell_y        <= y;
		cell_z        <= z;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic deposit(logic [POS_BITS-1:0] px, logic [POS_BITS-1:0] py,
			logic [POS_BITS-1:0] pz, logic [MASS_BITS-1:0] m);
		send(REQ_DEPOSIT, px, py, pz, m, GRID_BITS'($urandom), GRID_BITS'($urandom),
			GRID_BITS'($urandom));
	endtask

	task automatic read(logic [GRID_BITS-1:0] x, logic [GRID_BITS-1:0] y,
			logic [GRID_BITS-1:0] z);
		send(REQ_READ, POS_BITS'($urandom), POS_BITS'($urandom), POS_BITS'($urandom),
			$urandom, x, y, z);
	endtask

	// mostly near the wrap corner so reads find accumulated mass
	function automatic logic [POS_BITS-1:0] rand_pos();
		logic [GRID_BITS-1:0] c;
		logic [FRAC_BITS-1:0] f;
		if ($urandom_range(9) < 2)
			return POS_BITS'($urandom);
		c = GRID_BITS'($urandom_range(62, 65));
		case ($urandom_range(5))
			0:       f = '0;
			1:       f = '1;
			2:       f = HALF_FX;
			default: f = FRAC_BITS'($urandom);
		endcase
		return {c, f};
	endfunction

	function automatic logic [GRID_BITS-1:0] rand_cell();
		if ($urandom_range(9) == 0)
			return GRID_BITS'($urandom);
		return GRID_BITS'($urandom_range(61, 66));
	endfunction

	function automatic logic [MASS_BITS-1:0] rand_mass();
		case ($urandom_range(9))
			0:       return '1;
			1:       return MASS_BITS'($urandom_range(255));
			default: return $urandom;
		endcase
	endfunction

	localparam logic [POS_BITS-1:0] CENTRE5 = {6'd5, HALF_FX};

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme positions and masses, exact centres, saturation
		deposit('0, '0, '0, 32'd1000);
		deposit('1, '1, '1, 32'd1000);
		deposit({6'd63, HALF_FX}, {6'd0, HALF_FX}, '1, '1);
		deposit(CENTRE5, CENTRE5, CENTRE5, '1);
		deposit(CENTRE5, CENTRE5, CENTRE5, '1);
		deposit(CENTRE5, CENTRE5, CENTRE5, 32'd0);
		deposit(22'h2AAAAA, 22'h155555, 22'h3FFFFF, 32'hAAAA5555);
		read(6'd5, 6'd5, 6'd5);
		read(6'd5, 6'd5, 6'd5);
		read(6'd6, 6'd5, 6'd5);
		read(6'd63, 6'd63, 6'd63);
		read(6'd0, 6'd0, 6'd0);
		read(6'd63, 6'd0, 6'd63);
		read(6'd0, 6'd63, 6'd0);
		read(6'd42, 6'd21, 6'd62);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			case (i / (RAND_ITEMS / 4))
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 78; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 78; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			if ($urandom_range(99) < 65)
				deposit(rand_pos(), rand_pos(), rand_pos(), rand_mass());
			else
				read(rand_cell(), rand_cell(), rand_cell());
		end
		req_valid <= 1'b0;
		idle_pct = 0;

		while (sums_pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		stall_pct = 0;

		$display("covered %0d deposits and %0d reads, %0d saturated results seen",
			deposit_count, read_count, sat_seen);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
